[hw/rtl/baro_pressure_temp_compensation_unit_macros.svh]
// Assertion helpers for the checker file.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_UNIT_MACROS_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define BPTC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define BPTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/bptc_pkg.sv]
package bptc_pkg;

	// Field widths
	localparam int RAW_BITS   = 24;
	localparam int COEFF_BITS = 16;
	localparam int TEMP_W     = 19;
	localparam int PRES_W     = 32;

	// Shift amounts and scales of the compensation formulae
	localparam int REF_SCALE     = 8;
	localparam int OFF_SCALE     = 17;
	localparam int SENS_SCALE    = 16;
	localparam int TEMP_SHIFT    = 23;
	localparam int OFF_TC_SHIFT  = 6;
	localparam int SENS_TC_SHIFT = 7;
	localparam int T2_SHIFT      = 31;
	localparam int OFF2_SHIFT    = 4;
	localparam int P_SHIFT       = 21;
	localparam int PRES_SHIFT    = 15;

	// Temperature thresholds in hundredths of a degree
	localparam int T_REF  = 2000;
	localparam int T_COLD = -1500;

	// Internal widths
	localparam int DT_W    = ((RAW_BITS > COEFF_BITS + REF_SCALE) ?
	                          RAW_BITS : COEFF_BITS + REF_SCALE) + 1;
	localparam int MUL_W   = DT_W + COEFF_BITS + 1;
	localparam int TD_W    = MUL_W - TEMP_SHIFT;
	localparam int TEMP1_W = TD_W + 1;
	localparam int SQ_W    = 2 * DT_W;
	localparam int T2_W    = SQ_W - T2_SHIFT;
	localparam int TDSQ_W  = 2 * TD_W;
	localparam int VLSQ_W  = 2 * TEMP1_W;
	localparam int OFF_W   = 40;
	localparam int SENS_W  = 40;
	localparam int OFF2_W  = OFF_W + OFF2_SHIFT;
	localparam int SPLIT_W = SENS_W / 2;
	localparam int PROD_W  = RAW_BITS + SENS_W;

	// Port widths
	localparam int IN_W      = ((2 * RAW_BITS + 7) / 8) * 8;
	localparam int OUT_W     = ((TEMP_W + PRES_W + 7) / 8) * 8;
	localparam int CFG_IDX_W = 3;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SENS      = 3'd0,
		REG_OFF       = 3'd1,
		REG_SENS_TEMP = 3'd2,
		REG_OFF_TEMP  = 3'd3,
		REG_REF_TEMP  = 3'd4,
		REG_TEMP_SLOPE = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [COEFF_BITS-1:0] sens;
		logic [COEFF_BITS-1:0] off;
		logic [COEFF_BITS-1:0] sens_temp;
		logic [COEFF_BITS-1:0] off_temp;
		logic [COEFF_BITS-1:0] ref_temp;
		logic [COEFF_BITS-1:0] temp_slope;
	} cfg_t;

	// First-order results
	typedef struct packed {
		logic                       zero;
		logic [RAW_BITS-1:0]        d1;
		logic                       low;
		logic                       cold;
		logic signed [TD_W-1:0]     td;
		logic signed [TEMP1_W-1:0]  temp1;
		logic signed [TEMP1_W-1:0]  vl;
		logic signed [T2_W-1:0]     t2;
		logic signed [OFF_W-1:0]    off;
		logic signed [SENS_W-1:0]   sens;
	} first_t;

	// Corrected temperature, offset and sensitivity
	typedef struct packed {
		logic                      zero;
		logic [RAW_BITS-1:0]       d1;
		logic signed [TEMP_W-1:0]  temp;
		logic signed [OFF_W-1:0]   off;
		logic signed [SENS_W-1:0]  sens;
	} second_t;

endpackage

[hw/rtl/bptc_cfg_regs.sv]
module bptc_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bptc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bptc_pkg::COEFF_BITS-1:0]  cfg_data,
	output bptc_pkg::cfg_t                   cfg
);

	bptc_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Calibration words; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				bptc_pkg::REG_SENS:       cfg_q.sens       <= cfg_data;
				bptc_pkg::REG_OFF:        cfg_q.off        <= cfg_data;
				bptc_pkg::REG_SENS_TEMP:  cfg_q.sens_temp  <= cfg_data;
				bptc_pkg::REG_OFF_TEMP:   cfg_q.off_temp   <= cfg_data;
				bptc_pkg::REG_REF_TEMP:   cfg_q.ref_temp   <= cfg_data;
				bptc_pkg::REG_TEMP_SLOPE: cfg_q.temp_slope <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

[hw/rtl/bptc_first_order.sv]
module bptc_first_order (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bptc_pkg::cfg_t                 cfg,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [bptc_pkg::RAW_BITS-1:0]  raw_pressure,
	input  logic [bptc_pkg::RAW_BITS-1:0]  raw_temperature,
	output logic                           out_valid,
	input  logic                           out_ready,
	output bptc_pkg::first_t               out_data
);

	localparam int DT_W    = bptc_pkg::DT_W;
	localparam int MUL_W   = bptc_pkg::MUL_W;
	localparam int SQ_W    = bptc_pkg::SQ_W;
	localparam int TD_W    = bptc_pkg::TD_W;
	localparam int TEMP1_W = bptc_pkg::TEMP1_W;
	localparam int OFF_W   = bptc_pkg::OFF_W;
	localparam int SENS_W  = bptc_pkg::SENS_W;
	localparam int RAW_BITS = bptc_pkg::RAW_BITS;

	logic valid_s1, valid_s2, valid_s3;
	logic ready_s1, ready_s2, ready_s3;

	logic                     zero_s1, zero_s2;
	logic [RAW_BITS-1:0]      d1_s1, d1_s2;
	logic signed [DT_W-1:0]   dt_s1;
	logic signed [MUL_W-1:0]  p_temp_s2, p_off_s2, p_sens_s2;
	logic signed [SQ_W-1:0]   p_sq_s2;
	bptc_pkg::first_t         res_s3;

	logic signed [DT_W-1:0]   dt_c;
	bptc_pkg::first_t         res_c;

	// Stall chain: a stage takes data when empty or when it moves on
	assign ready_s3  = !valid_s3 || out_ready;
	assign ready_s2  = !valid_s2 || ready_s3;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign in_ready  = ready_s1;
	assign out_valid = valid_s3;
	assign out_data  = res_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	// Stage 1: temperature difference dT
	assign dt_c = $signed(DT_W'(raw_temperature))
	            - $signed(DT_W'({cfg.ref_temp, {bptc_pkg::REF_SCALE{1'b0}}}));

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			zero_s1 <= (raw_pressure == '0) || (raw_temperature == '0);
			d1_s1   <= raw_pressure;
			dt_s1   <= dt_c;
		end
	end

	// Stage 2: products with dT
	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			zero_s2   <= zero_s1;
			d1_s2     <= d1_s1;
			p_temp_s2 <= MUL_W'(dt_s1 * $signed({1'b0, cfg.temp_slope}));
			p_off_s2  <= MUL_W'(dt_s1 * $signed({1'b0, cfg.off_temp}));
			p_sens_s2 <= MUL_W'(dt_s1 * $signed({1'b0, cfg.sens_temp}));
			p_sq_s2   <= SQ_W'(dt_s1 * dt_s1);
		end
	end

	// Stage 3: first-order temperature, offset and sensitivity
	always_comb begin
		res_c.zero  = zero_s2;
		res_c.d1    = d1_s2;
		res_c.td    = $signed(p_temp_s2[MUL_W-1:bptc_pkg::TEMP_SHIFT]);
		res_c.temp1 = TEMP1_W'(res_c.td) + $signed(TEMP1_W'(bptc_pkg::T_REF));
		res_c.vl    = res_c.temp1 - $signed(TEMP1_W'(bptc_pkg::T_COLD));
		res_c.low   = res_c.td[TD_W-1];
		res_c.cold  = res_c.vl[TEMP1_W-1];
		res_c.t2    = $signed(p_sq_s2[SQ_W-1:bptc_pkg::T2_SHIFT]);
		res_c.off   = $signed(OFF_W'({cfg.off, {bptc_pkg::OFF_SCALE{1'b0}}}))
		            + OFF_W'($signed(p_off_s2[MUL_W-1:bptc_pkg::OFF_TC_SHIFT]));
		res_c.sens  = $signed(SENS_W'({cfg.sens, {bptc_pkg::SENS_SCALE{1'b0}}}))
		            + SENS_W'($signed(p_sens_s2[MUL_W-1:bptc_pkg::SENS_TC_SHIFT]));
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			res_s3 <= res_c;
		end
	end

endmodule

[hw/rtl/bptc_second_order.sv]
module bptc_second_order (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bptc_pkg::first_t   in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output bptc_pkg::second_t  out_data
);

	localparam int TDSQ_W  = bptc_pkg::TDSQ_W;
	localparam int VLSQ_W  = bptc_pkg::VLSQ_W;
	localparam int TEMP1_W = bptc_pkg::TEMP1_W;
	localparam int TEMP_W  = bptc_pkg::TEMP_W;
	localparam int OFF_W   = bptc_pkg::OFF_W;
	localparam int SENS_W  = bptc_pkg::SENS_W;
	localparam int OFF2_W  = bptc_pkg::OFF2_W;

	logic valid_s4, valid_s5;
	logic ready_s4, ready_s5;

	bptc_pkg::first_t          fo_s4;
	logic signed [TDSQ_W-1:0]  tdsq_s4;
	logic signed [VLSQ_W-1:0]  vlsq_s4;
	bptc_pkg::second_t         res_s5;

	logic signed [OFF2_W-1:0]  off2_full;
	logic signed [OFF_W-1:0]   vlsq_ext, off2, sens2;
	logic signed [TEMP1_W-1:0] temp_full;
	bptc_pkg::second_t         res_c;

	assign ready_s5  = !valid_s5 || out_ready;
	assign ready_s4  = !valid_s4 || ready_s5;
	assign in_ready  = ready_s4;
	assign out_valid = valid_s5;
	assign out_data  = res_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (ready_s4) valid_s4 <= in_valid;
			if (ready_s5) valid_s5 <= valid_s4;
		end
	end

	// Stage 4: squares of the distances below 20 C and below -15 C
	always_ff @(posedge clk) begin
		if (ready_s4 && in_valid) begin
			fo_s4   <= in_data;
			tdsq_s4 <= TDSQ_W'(in_data.td * in_data.td);
			vlsq_s4 <= VLSQ_W'(in_data.vl * in_data.vl);
		end
	end

	// Stage 5: second-order corrections, applied only below 20 C
	always_comb begin
		// 61 * td^2 as shift-and-add, then floor divide by 16
		off2_full = (OFF2_W'(tdsq_s4) <<< 6) - (OFF2_W'(tdsq_s4) <<< 2)
		          + OFF2_W'(tdsq_s4);
		vlsq_ext  = OFF_W'(vlsq_s4);
		off2      = OFF_W'(off2_full >>> bptc_pkg::OFF2_SHIFT);
		sens2     = SENS_W'(tdsq_s4) <<< 1;
		// extra terms below -15 C: 15 * vl^2 and 8 * vl^2
		if (fo_s4.cold) begin
			off2  = off2 + (vlsq_ext <<< 4) - vlsq_ext;
			sens2 = sens2 + (vlsq_ext <<< 3);
		end

		temp_full  = fo_s4.temp1;
		res_c.zero = fo_s4.zero;
		res_c.d1   = fo_s4.d1;
		res_c.off  = fo_s4.off;
		res_c.sens = fo_s4.sens;
		if (fo_s4.low) begin
			temp_full  = fo_s4.temp1 - TEMP1_W'(fo_s4.t2);
			res_c.off  = fo_s4.off - off2;
			res_c.sens = fo_s4.sens - sens2;
		end
		res_c.temp = TEMP_W'(temp_full);
	end

	always_ff @(posedge clk) begin
		if (ready_s5 && valid_s4) begin
			res_s5 <= res_c;
		end
	end

endmodule

[hw/rtl/bptc_pressure.sv]
module bptc_pressure (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  bptc_pkg::second_t                in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [bptc_pkg::TEMP_W-1:0] temperature_centi,
	output logic signed [bptc_pkg::PRES_W-1:0] pressure_centi_mbar,
	output logic                             valid_res
);

	localparam int RAW_BITS = bptc_pkg::RAW_BITS;
	localparam int SPLIT_W  = bptc_pkg::SPLIT_W;
	localparam int SENS_W   = bptc_pkg::SENS_W;
	localparam int OFF_W    = bptc_pkg::OFF_W;
	localparam int PROD_W   = bptc_pkg::PROD_W;
	localparam int TEMP_W   = bptc_pkg::TEMP_W;
	localparam int PRES_W   = bptc_pkg::PRES_W;
	localparam int LO_W     = RAW_BITS + SPLIT_W;
	localparam int HI_W     = RAW_BITS + 1 + SENS_W - SPLIT_W;

	logic valid_s6, valid_s7, valid_s8;
	logic ready_s6, ready_s7, ready_s8;

	logic                      zero_s6, zero_s7;
	logic signed [TEMP_W-1:0]  temp_s6, temp_s7;
	logic signed [OFF_W-1:0]   off_s6, off_s7;
	logic [LO_W-1:0]           pp_lo_s6;
	logic signed [HI_W-1:0]    pp_hi_s6;
	logic signed [PROD_W-1:0]  prod_s7;
	logic signed [TEMP_W-1:0]  temp_s8;
	logic signed [PRES_W-1:0]  pres_s8;
	logic                      vres_s8;

	logic signed [PROD_W-1:0]  prod_c;
	logic signed [PROD_W-1:0]  p64_c;

	assign ready_s8  = !valid_s8 || out_ready;
	assign ready_s7  = !valid_s7 || ready_s8;
	assign ready_s6  = !valid_s6 || ready_s7;
	assign in_ready  = ready_s6;
	assign out_valid = valid_s8;

	assign temperature_centi   = temp_s8;
	assign pressure_centi_mbar = pres_s8;
	assign valid_res           = vres_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			if (ready_s6) valid_s6 <= in_valid;
			if (ready_s7) valid_s7 <= valid_s6;
			if (ready_s8) valid_s8 <= valid_s7;
		end
	end

	// Stage 6: D1 * SENS as two partial products on the sensitivity halves
	always_ff @(posedge clk) begin
		if (ready_s6 && in_valid) begin
			zero_s6  <= in_data.zero;
			temp_s6  <= in_data.temp;
			off_s6   <= in_data.off;
			pp_lo_s6 <= LO_W'(in_data.d1 * in_data.sens[SPLIT_W-1:0]);
			pp_hi_s6 <= HI_W'($signed({1'b0, in_data.d1})
			          * $signed(in_data.sens[SENS_W-1:SPLIT_W]));
		end
	end

	// Stage 7: recombine the partial products
	assign prod_c = (PROD_W'(pp_hi_s6) <<< SPLIT_W) + $signed(PROD_W'(pp_lo_s6));

	always_ff @(posedge clk) begin
		if (ready_s7 && valid_s6) begin
			zero_s7 <= zero_s6;
			temp_s7 <= temp_s6;
			off_s7  <= off_s6;
			prod_s7 <= prod_c;
		end
	end

	// Stage 8: subtract offset, scale down, zero the result on a zero raw value
	assign p64_c = (prod_s7 >>> bptc_pkg::P_SHIFT) - PROD_W'(off_s7);

	always_ff @(posedge clk) begin
		if (ready_s8 && valid_s7) begin
			if (zero_s7) begin
				temp_s8 <= '0;
				pres_s8 <= '0;
				vres_s8 <= 1'b0;
			end else begin
				temp_s8 <= temp_s7;
				pres_s8 <= p64_c[PRES_W+bptc_pkg::PRES_SHIFT-1:bptc_pkg::PRES_SHIFT];
				vres_s8 <= 1'b1;
			end
		end
	end

endmodule

[hw/rtl/baro_pressure_temp_compensation_unit.sv]
// Second-order temperature compensation of a barometric sensor: each accepted
// s_tdata word carries a raw pressure and a raw temperature conversion, and the
// matching m_tdata word gives the temperature in 0.01 C and the low 32 bits of
// the pressure in 0.01 mbar, with m_tuser high for a valid result (low, with
// zero data, when either raw value was zero). The block takes one sample pair
// every clock cycle while m_tready is high; each result passes through eight
// register stages (dT, the dT products, first-order terms, the squares,
// second-order correction, the two halves of the D1 by SENS product, their sum,
// and the output register). s_tready falls only once every stage is full and
// m_tready is low. The six calibration words are written through the cfg port,
// which never stalls; the user must write them only while no sample is in flight,
// as the block itself does not enforce this. All of them reset to zero.
module baro_pressure_temp_compensation_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [bptc_pkg::IN_W-1:0]        s_tdata,   // raw_pressure, raw_temperature
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [bptc_pkg::OUT_W-1:0]       m_tdata,   // temperature_centi, pressure_centi_mbar
	output logic                             m_tuser,   // valid_res
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bptc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bptc_pkg::COEFF_BITS-1:0]  cfg_data
);

	localparam int RAW_BITS = bptc_pkg::RAW_BITS;
	localparam int TEMP_W   = bptc_pkg::TEMP_W;
	localparam int PRES_W   = bptc_pkg::PRES_W;
	localparam int OUT_W    = bptc_pkg::OUT_W;

	bptc_pkg::cfg_t     cfg;
	bptc_pkg::first_t   fo_data;
	bptc_pkg::second_t  so_data;
	logic               fo_valid, fo_ready, so_valid, so_ready;

	logic signed [TEMP_W-1:0] temperature_centi;
	logic signed [PRES_W-1:0] pressure_centi_mbar;

	bptc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bptc_first_order u_first (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.in_valid        (s_tvalid),
		.in_ready        (s_tready),
		.raw_pressure    (s_tdata[RAW_BITS-1:0]),
		.raw_temperature (s_tdata[2*RAW_BITS-1:RAW_BITS]),
		.out_valid       (fo_valid),
		.out_ready       (fo_ready),
		.out_data        (fo_data)
	);

	bptc_second_order u_second (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fo_valid),
		.in_ready  (fo_ready),
		.in_data   (fo_data),
		.out_valid (so_valid),
		.out_ready (so_ready),
		.out_data  (so_data)
	);

	bptc_pressure u_pressure (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (so_valid),
		.in_ready            (so_ready),
		.in_data             (so_data),
		.out_valid           (m_tvalid),
		.out_ready           (m_tready),
		.temperature_centi   (temperature_centi),
		.pressure_centi_mbar (pressure_centi_mbar),
		.valid_res           (m_tuser)
	);

	// Pack result fields from the low bit up, zero padded to whole bytes
	assign m_tdata = OUT_W'({pressure_centi_mbar, temperature_centi});

endmodule

[hw/rtl/bptc_checker.sv]
`include "baro_pressure_temp_compensation_unit_macros.svh"

module bptc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [bptc_pkg::OUT_W-1:0]  m_tdata,
	input logic                        m_tuser,
	input logic                        cfg_valid,
	input logic                        cfg_ready
);

	// Input side only backs up when the whole pipeline is full and stalled
	`BPTC_ASSERT_NOW(a_in_stall, clk, arst_n, !s_tready, m_tvalid && !m_tready, "s_tready low without a stalled output")

	// A rejected sample pair carries zero data
	`BPTC_ASSERT_NOW(a_zero_data, clk, arst_n, m_tvalid && !m_tuser, m_tdata == '0, "invalid result with non-zero data")

	// Configuration writes are never held off
	`BPTC_ASSERT_NOW(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready, "configuration write stalled")

	// A stalled result stays put
	`BPTC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind baro_pressure_temp_compensation_unit bptc_checker u_checker (.*);

[tb/baro_pressure_temp_compensation_unit_test.sv]
`timescale 1ns / 1ps

module baro_pressure_temp_compensation_unit_test;
	import bptc_pkg::*;

	localparam int     CYCLE_LIMIT = 400000;
	localparam int     REPORT_MAX  = 10;
	localparam int     PHASES      = 8;
	localparam int     PHASE_ITEMS = 212;
	localparam longint RAW_MAX     = (longint'(1) << RAW_BITS) - 1;

	// Indexes beyond the register file, writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

	typedef logic [COEFF_BITS-1:0] cal_words_t [6];

	typedef enum logic [1:0] {
		CAL_RESET,
		CAL_TYPICAL,
		CAL_FULL
	} cal_set_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic signed [PRES_W-1:0] pres;
		logic                     ok;
	} reading_t;

	typedef struct packed {
		cal_set_t            cal;
		logic [RAW_BITS-1:0] p_raw;
		logic [RAW_BITS-1:0] t_raw;
		logic                fixed;
		reading_t            want;
	} probe_t;

	localparam reading_t  NO_READING  = '{19'sd0, 32'sd0, 1'b0};
	localparam reading_t  AT_RESET    = '{19'sd2000, 32'sd0, 1'b1};
	localparam cal_words_t TYPICAL_CAL = '{16'd46372, 16'd43981, 16'd29059,
	                                       16'd27842, 16'd31553, 16'd28165};
	localparam cal_words_t FULL_CAL    = '{default: 16'hFFFF};
	localparam cal_words_t ZERO_CAL    = '{default: 16'h0000};

	// Directed probes: reset values, zero inputs, both temperature thresholds,
	// deep cold and full-scale calibration where the pressure wraps
	probe_t probes [22] = '{
		'{CAL_RESET,   24'd1,       24'd1,       1'b1, AT_RESET},
		'{CAL_RESET,   24'hFFFFFF,  24'hFFFFFF,  1'b1, AT_RESET},
		'{CAL_RESET,   24'd0,       24'h800000,  1'b1, NO_READING},
		'{CAL_RESET,   24'h800000,  24'd0,       1'b1, NO_READING},
		'{CAL_RESET,   24'd0,       24'd0,       1'b1, NO_READING},
		'{CAL_RESET,   24'hAAAAAA,  24'h555555,  1'b1, AT_RESET},
		'{CAL_TYPICAL, 24'd6465444, 24'd8577568, 1'b0, NO_READING},
		'{CAL_TYPICAL, 24'd6465444, 24'd8077568, 1'b0, NO_READING},
		'{CAL_TYPICAL, 24'd6465444, 24'd8077567, 1'b0, NO_READING},
		'{CAL_TYPICAL, 24'd6465444, 24'd7077568, 1'b0, NO_READING},
		'{CAL_TYPICAL, 24'd6465444, 24'd7035135, 1'b0, NO_READING},
		'{CAL_TYPICAL, 24'd6465444, 24'd7035134, 1'b0, NO_READING},
		'{CAL_TYPICAL, 24'd6465444, 24'd6077568, 1'b0, NO_READING},
		'{CAL_TYPICAL, 24'hFFFFFF,  24'hFFFFFF,  1'b0, NO_READING},
		'{CAL_TYPICAL, 24'd1,       24'd1,       1'b0, NO_READING},
		'{CAL_TYPICAL, 24'd0,       24'd7035134, 1'b1, NO_READING},
		'{CAL_TYPICAL, 24'h555555,  24'hAAAAAA,  1'b0, NO_READING},
		'{CAL_FULL,    24'hFFFFFF,  24'hFFFFFF,  1'b0, NO_READING},
		'{CAL_FULL,    24'd1,       24'd1,       1'b0, NO_READING},
		'{CAL_FULL,    24'hFFFFFF,  24'd1,       1'b0, NO_READING},
		'{CAL_FULL,    24'd1,       24'hFFFFFF,  1'b0, NO_READING},
		'{CAL_FULL,    24'hFFFFFF,  24'd0,       1'b1, NO_READING}
	};

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_W-1:0]      m_tdata;
	logic                  m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [COEFF_BITS-1:0] cfg_data  = '0;

	// Calibration words as the block should hold them
	cal_words_t cal_word = ZERO_CAL;
	reading_t   pending_readings [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int cycles = 0;
	int sent_count = 0;
	int checked_count = 0;
	int mismatch_count = 0;
	int orphan_count = 0;
	int cal_loads = 0;
	int low_count = 0;
	int cold_count = 0;
	int zero_count = 0;

	baro_pressure_temp_compensation_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Second-order compensation of one raw pair under the current calibration
	function automatic reading_t compensate(input logic [RAW_BITS-1:0] p_raw,
	                                        input logic [RAW_BITS-1:0] t_raw);
		longint d1, d2, dt, temp, off, sens, t2, td, off2, sens2, vl, p64, pres;
		reading_t r;
		d1 = longint'(p_raw);
		d2 = longint'(t_raw);
		if (d1 == 0 || d2 == 0) begin
			zero_count++;
			return NO_READING;
		end
		dt   = d2 - (longint'(cal_word[REG_REF_TEMP]) << REF_SCALE);
		temp = T_REF + ((dt * longint'(cal_word[REG_TEMP_SLOPE])) >>> TEMP_SHIFT);
		off  = (longint'(cal_word[REG_OFF]) << OFF_SCALE)
		     + ((longint'(cal_word[REG_OFF_TEMP]) * dt) >>> OFF_TC_SHIFT);
		sens = (longint'(cal_word[REG_SENS]) << SENS_SCALE)
		     + ((longint'(cal_word[REG_SENS_TEMP]) * dt) >>> SENS_TC_SHIFT);
		// below 20 C: second-order terms, extra ones below -15 C
		if (temp < T_REF) begin
			low_count++;
			t2    = (dt * dt) >>> T2_SHIFT;
			td    = temp - T_REF;
			off2  = (61 * td * td) >>> OFF2_SHIFT;
			sens2 = 2 * td * td;
			if (temp < T_COLD) begin
				cold_count++;
				vl = temp - T_COLD;
				off2  += 15 * vl * vl;
				sens2 += 8 * vl * vl;
			end
			temp -= t2;
			off  -= off2;
			sens -= sens2;
		end
		p64    = ((d1 * sens) >>> P_SHIFT) - off;
		pres   = p64 >>> PRES_SHIFT;
		r.temp = temp[TEMP_W-1:0];
		r.pres = pres[PRES_W-1:0];
		r.ok   = 1'b1;
		return r;
	endfunction

	function automatic logic [RAW_BITS-1:0] pick_pressure_raw();
		case ($urandom_range(31))
			0: return '0;
			1: return '1;
			2: return RAW_BITS'(1);
			3: return RAW_BITS'($urandom_range(255));
			default: return RAW_BITS'($urandom);
		endcase
	endfunction

	// Mostly near the reference point so that all three temperature bands show up
	function automatic logic [RAW_BITS-1:0] pick_temperature_raw();
		longint centre, span, offset, v;
		centre = longint'(cal_word[REG_REF_TEMP]) << REF_SCALE;
		case ($urandom_range(15))
			0: return ($urandom_range(1) != 0) ? '0 : '1;
			1, 2, 3: return RAW_BITS'($urandom);
			default: begin
				span   = longint'(1) << $urandom_range(RAW_BITS - 1);
				offset = longint'($urandom) % span;
				v = ($urandom_range(1) != 0) ? centre + offset : centre - offset;
				if (v < 1)
					v = 1;
				if (v > RAW_MAX)
					v = RAW_MAX;
				return v[RAW_BITS-1:0];
			end
		endcase
	endfunction

	function automatic logic [COEFF_BITS-1:0] pick_word(input logic [COEFF_BITS-1:0] typical);
		int v;
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2, 3: return COEFF_BITS'($urandom);
			default: begin
				v = int'(typical) + int'($urandom_range(8000)) - 4000;
				if (v < 0)
					v = 0;
				if (v > 65535)
					v = 65535;
				return COEFF_BITS'(v);
			end
		endcase
	endfunction

	task automatic write_cal(input logic [CFG_IDX_W-1:0] idx, input logic [COEFF_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx <= REG_TEMP_SLOPE)
			cal_word[idx] = val;
		@(posedge clk);
	endtask

	task automatic load_cal(input cal_words_t words);
		write_cal(IDX_SPARE_LO, COEFF_BITS'($urandom));
		write_cal(REG_TEMP_SLOPE, words[REG_TEMP_SLOPE]);
		write_cal(REG_SENS, words[REG_SENS]);
		write_cal(REG_OFF, words[REG_OFF]);
		write_cal(REG_SENS_TEMP, words[REG_SENS_TEMP]);
		write_cal(REG_OFF_TEMP, words[REG_OFF_TEMP]);
		write_cal(REG_REF_TEMP, words[REG_REF_TEMP]);
		write_cal(IDX_SPARE_HI, COEFF_BITS'($urandom));
		cal_loads++;
	endtask

	// Present one raw pair, holding tvalid until the transaction completes
	task automatic send_pair(input logic [RAW_BITS-1:0] p_raw, input logic [RAW_BITS-1:0] t_raw,
	                         input reading_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {t_raw, p_raw};
		pending_readings.push_back(want);
		do @(posedge clk); while (!s_tready);
		sent_count++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
			default: begin send_idle_pct = 27; recv_stall_pct = 27; end
		endcase
	endtask

	// Result check and receiver stalls
	always @(posedge clk) begin
		reading_t got;
		reading_t want;
		if (m_tvalid && m_tready) begin
			got.temp = m_tdata[TEMP_W-1:0];
			got.pres = m_tdata[TEMP_W +: PRES_W];
			got.ok   = m_tuser;
			if (pending_readings.size() == 0) begin
				orphan_count++;
				if (orphan_count + mismatch_count <= REPORT_MAX)
					$display("unexpected reading T=%0d P=%0d V=%0b", got.temp, got.pres, got.ok);
			end else begin
				want = pending_readings.pop_front();
				checked_count++;
				if (got.temp !== want.temp || got.pres !== want.pres || got.ok !== want.ok) begin
					mismatch_count++;
					if (orphan_count + mismatch_count <= REPORT_MAX)
						$display("reading %0d: expected T=%0d P=%0d V=%0b, got T=%0d P=%0d V=%0b",
						         checked_count, want.temp, want.pres, want.ok,
						         got.temp, got.pres, got.ok);
				end
			end
		end
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		cal_set_t   loaded;
		cal_words_t words;
		logic [RAW_BITS-1:0] p_raw;
		logic [RAW_BITS-1:0] t_raw;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed probes, back to back
		set_idling(0);
		loaded = CAL_RESET;
		foreach (probes[i]) begin
			if (probes[i].cal != loaded) begin
				drain();
				if (probes[i].cal == CAL_FULL)
					load_cal(FULL_CAL);
				else
					load_cal(TYPICAL_CAL);
				loaded = probes[i].cal;
			end
			send_pair(probes[i].p_raw, probes[i].t_raw,
			          probes[i].fixed ? probes[i].want : compensate(probes[i].p_raw,
			                                                        probes[i].t_raw));
		end

		// Random phases, each with a calibration load and one of four idling patterns
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph)
				0: words = TYPICAL_CAL;
				1: words = FULL_CAL;
				2: words = ZERO_CAL;
				default: foreach (words[i]) words[i] = pick_word(TYPICAL_CAL[i]);
			endcase
			load_cal(words);
			set_idling(ph % 4);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// one hold-off mid-stream until the pipeline has emptied
				if (ph == 5 && n == PHASE_ITEMS / 2)
					drain();
				p_raw = pick_pressure_raw();
				t_raw = pick_temperature_raw();
				send_pair(p_raw, t_raw, compensate(p_raw, t_raw));
			end
		end

		drain();
		repeat (20) @(posedge clk);

		$display("%0d sample pairs over %0d calibration loads, %0d readings compared",
		         sent_count, cal_loads, checked_count);
		$display("below 20 C: %0d, below -15 C: %0d, zero raw input: %0d, mismatches: %0d",
		         low_count, cold_count, zero_count, mismatch_count + orphan_count);
		if (mismatch_count == 0 && orphan_count == 0 && pending_readings.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
